FILE: rtl/core/ismt_pkg.sv
// Shared types and constants for the interval set merge table.
package ismt_pkg;

	localparam int MAX_INTERVALS_DEF = 16;
	localparam int VALUE_BITS_DEF    = 32;

	typedef enum logic [1:0] {
		STATUS_ADDED   = 2'd0,
		STATUS_FULL    = 2'd1,
		STATUS_LISTED  = 2'd2,
		STATUS_EMPTY   = 2'd3
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_SCAN_RD,
		S_SCAN_EV,
		S_DECIDE,
		S_UP_RD,
		S_UP_WR,
		S_NEW_WR,
		S_MERGE_WR,
		S_DN_RD,
		S_DN_WR,
		S_SHRINK,
		S_ADDED,
		S_DROPPED,
		S_EMPTY,
		S_LIST_RD,
		S_LIST_EM
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic    load;
		logic    rd;
		logic    scan_ev;
		logic    scan_end;
		logic    up_start;
		logic    up_wr;
		logic    new_wr;
		logic    merge_wr;
		logic    dn_wr;
		logic    shrink;
		logic    list_next;
		logic    out_load;
		logic    out_list;
		status_t out_code;
	} dp_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic in_list;
		logic cnt_zero;
		logic full;
		logic idx_at_n;
		logic ev_stop;
		logic j_eq_i;
		logic i_eq_n;
		logic j_eq_n;
		logic idx_eq_i;
		logic idx_last;
		logic out_free;
	} dp_stat_t;

endpackage

FILE: rtl/core/ismt_ram.sv
// Generic simple dual-port RAM with registered read.
module ismt_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

FILE: rtl/core/ismt_datapath.sv
// Datapath: interval RAM, scan compares, shift addressing and output register.
module ismt_datapath #(
	parameter int MAX_INTERVALS = ismt_pkg::MAX_INTERVALS_DEF,
	parameter int VALUE_BITS    = ismt_pkg::VALUE_BITS_DEF,
	localparam int CB           = $clog2(MAX_INTERVALS + 1)
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  ismt_pkg::dp_cmd_t            cmd,
	output ismt_pkg::dp_stat_t           stat,
	input  logic                         list_req,
	input  logic signed [VALUE_BITS-1:0] range_start,
	input  logic signed [VALUE_BITS-1:0] range_end,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [1:0]                   status,
	output logic signed [VALUE_BITS-1:0] interval_low,
	output logic signed [VALUE_BITS-1:0] interval_high,
	output logic [CB-1:0]                interval_count,
	output logic                         last
);
	import ismt_pkg::*;

	localparam int AW = $clog2(MAX_INTERVALS);
	localparam int DW = 2 * VALUE_BITS;

	logic signed [VALUE_BITS-1:0] a_q, b_q, lo_q, hi_q;
	logic [CB-1:0]                cnt_q, idx_q, i_q, j_q;
	logic                         found_q;

	logic [DW-1:0]                rd_data;
	logic signed [VALUE_BITS-1:0] rd_low, rd_high;
	logic                         hi_lt_a, b_lt_lo, skip;
	logic [CB-1:0]                gone, idx_inc, idx_dec;

	logic                         wr_en;
	logic [CB-1:0]                wr_addr;
	logic [DW-1:0]                wr_data;

	logic                         out_valid_q;
	status_t                      out_status_q;
	logic signed [VALUE_BITS-1:0] out_low_q, out_high_q;
	logic [CB-1:0]                out_cnt_q;
	logic                         out_last_q;

	// RAM word: high end in the upper half, low end in the lower half
	assign rd_low  = $signed(rd_data[VALUE_BITS-1:0]);
	assign rd_high = $signed(rd_data[DW-1:VALUE_BITS]);

	assign hi_lt_a = rd_high < a_q;
	assign b_lt_lo = b_q < rd_low;
	// still before the first overlapping entry
	assign skip    = !found_q && hi_lt_a;

	assign gone    = j_q - i_q - CB'(1);
	assign idx_inc = idx_q + CB'(1);
	assign idx_dec = idx_q - CB'(1);

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = '0;
		wr_data = '0;
		unique if (cmd.up_wr) begin
			wr_en   = 1'b1;
			wr_addr = idx_inc;
			wr_data = rd_data;
		end else if (cmd.new_wr) begin
			wr_en   = 1'b1;
			wr_addr = i_q;
			wr_data = {b_q, a_q};
		end else if (cmd.merge_wr) begin
			wr_en   = 1'b1;
			wr_addr = i_q;
			wr_data = {hi_q, lo_q};
		end else if (cmd.dn_wr) begin
			wr_en   = 1'b1;
			wr_addr = idx_q - gone;
			wr_data = rd_data;
		end else begin
			wr_en   = 1'b0;
		end
	end

	ismt_ram #(
		.WIDTH (DW),
		.DEPTH (MAX_INTERVALS)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr[AW-1:0]),
		.wr_data (wr_data),
		.rd_en   (cmd.rd),
		.rd_addr (idx_q[AW-1:0]),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			if (range_end < range_start) begin
				a_q <= range_end;
				b_q <= range_start;
			end else begin
				a_q <= range_start;
				b_q <= range_end;
			end
			idx_q <= '0;
		end
		if (cmd.scan_ev) begin
			if (!skip && !found_q) begin
				i_q  <= idx_q;
				lo_q <= (rd_low < a_q) ? rd_low : a_q;
			end
			if (!skip && b_lt_lo) begin
				j_q <= idx_q;
			end else begin
				idx_q <= idx_inc;
			end
			if (!skip && !b_lt_lo) begin
				hi_q <= (b_q < rd_high) ? rd_high : b_q;
			end
		end
		if (cmd.scan_end) begin
			if (!found_q) begin
				i_q <= cnt_q;
			end
			j_q <= cnt_q;
		end
		if (cmd.up_start) begin
			idx_q <= cnt_q - CB'(1);
		end
		if (cmd.up_wr) begin
			idx_q <= idx_dec;
		end
		if (cmd.merge_wr) begin
			idx_q <= j_q;
		end
		if (cmd.dn_wr || cmd.list_next) begin
			idx_q <= idx_inc;
		end
		if (cmd.out_load) begin
			out_status_q <= cmd.out_code;
			out_cnt_q    <= cnt_q;
			if (cmd.out_list) begin
				out_low_q  <= rd_low;
				out_high_q <= rd_high;
				out_last_q <= stat.idx_last;
			end else begin
				out_low_q  <= '0;
				out_high_q <= '0;
				out_last_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			found_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.new_wr) begin
				cnt_q <= cnt_q + CB'(1);
			end else if (cmd.shrink) begin
				cnt_q <= cnt_q - gone;
			end
			if (cmd.load) begin
				found_q <= 1'b0;
			end else if (cmd.scan_ev && !skip) begin
				found_q <= 1'b1;
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		stat.in_list  = list_req;
		stat.cnt_zero = cnt_q == '0;
		stat.full     = cnt_q == CB'(MAX_INTERVALS);
		stat.idx_at_n = idx_q == cnt_q;
		stat.ev_stop  = !skip && b_lt_lo;
		stat.j_eq_i   = j_q == i_q;
		stat.i_eq_n   = i_q == cnt_q;
		stat.j_eq_n   = j_q == cnt_q;
		stat.idx_eq_i = idx_q == i_q;
		stat.idx_last = idx_inc == cnt_q;
		stat.out_free = !out_valid_q || out_ready;
	end

	assign out_valid      = out_valid_q;
	assign status         = out_status_q;
	assign interval_low   = out_low_q;
	assign interval_high  = out_high_q;
	assign interval_count = out_cnt_q;
	assign last           = out_last_q;

endmodule

FILE: rtl/core/ismt_ctrl.sv
// Controller state machine sequencing scan, shift, merge and listing.
module ismt_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  ismt_pkg::dp_stat_t stat,
	output ismt_pkg::dp_cmd_t  cmd
);
	import ismt_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					if (!stat.in_list) begin
						state_d = S_SCAN_RD;
					end else if (stat.cnt_zero) begin
						state_d = S_EMPTY;
					end else begin
						state_d = S_LIST_RD;
					end
				end
			end
			S_SCAN_RD: begin
				state_d = stat.idx_at_n ? S_DECIDE : S_SCAN_EV;
			end
			S_SCAN_EV: begin
				state_d = stat.ev_stop ? S_DECIDE : S_SCAN_RD;
			end
			S_DECIDE: begin
				priority if (!stat.j_eq_i) begin
					state_d = S_MERGE_WR;
				end else if (stat.full) begin
					state_d = S_DROPPED;
				end else if (stat.i_eq_n) begin
					state_d = S_NEW_WR;
				end else begin
					state_d = S_UP_RD;
				end
			end
			S_UP_RD:    state_d = S_UP_WR;
			S_UP_WR:    state_d = stat.idx_eq_i ? S_NEW_WR : S_UP_RD;
			S_NEW_WR:   state_d = S_ADDED;
			S_MERGE_WR: state_d = stat.j_eq_n ? S_SHRINK : S_DN_RD;
			S_DN_RD:    state_d = S_DN_WR;
			S_DN_WR:    state_d = stat.idx_last ? S_SHRINK : S_DN_RD;
			S_SHRINK:   state_d = S_ADDED;
			S_ADDED, S_DROPPED, S_EMPTY: begin
				if (stat.out_free) begin
					state_d = S_IDLE;
				end
			end
			S_LIST_RD:  state_d = S_LIST_EM;
			S_LIST_EM: begin
				if (stat.out_free) begin
					state_d = stat.idx_last ? S_IDLE : S_LIST_RD;
				end
			end
			default:    state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			S_SCAN_RD: begin
				cmd.scan_end = stat.idx_at_n;
				cmd.rd       = !stat.idx_at_n;
			end
			S_SCAN_EV:  cmd.scan_ev  = 1'b1;
			S_DECIDE:   cmd.up_start = stat.j_eq_i && !stat.full && !stat.i_eq_n;
			S_UP_RD:    cmd.rd       = 1'b1;
			S_UP_WR:    cmd.up_wr    = 1'b1;
			S_NEW_WR:   cmd.new_wr   = 1'b1;
			S_MERGE_WR: cmd.merge_wr = 1'b1;
			S_DN_RD:    cmd.rd       = 1'b1;
			S_DN_WR:    cmd.dn_wr    = 1'b1;
			S_SHRINK:   cmd.shrink   = 1'b1;
			S_ADDED: begin
				cmd.out_load = stat.out_free;
				cmd.out_code = STATUS_ADDED;
			end
			S_DROPPED: begin
				cmd.out_load = stat.out_free;
				cmd.out_code = STATUS_FULL;
			end
			S_EMPTY: begin
				cmd.out_load = stat.out_free;
				cmd.out_code = STATUS_EMPTY;
			end
			S_LIST_RD:  cmd.rd = 1'b1;
			S_LIST_EM: begin
				cmd.out_load  = stat.out_free;
				cmd.out_list  = 1'b1;
				cmd.list_next = stat.out_free;
				cmd.out_code  = STATUS_LISTED;
			end
			default:    cmd = '0;
		endcase
	end

endmodule

FILE: rtl/core/interval_set_merge_table_unit.sv
// Top level of the interval set merge table: stream ports, controller and datapath.
//
// Holds up to MAX_INTERVALS sorted, disjoint closed intervals in a single RAM with one
// write and one registered read port. An add (tuser 0) scans the table from the bottom
// with a read and an evaluate step per entry looked at, up to the end of the overlapping
// run, then shifts the entries behind the insertion point with a read and a write per
// moved entry; around these come the accept, decision, write and result steps. Entries
// move down after a merge and up before a plain insert. A listing (tuser 1) gives one
// transaction per stored interval, each a read and an emit step that waits while the
// output is stalled, or a single empty-set transaction. The RAM port is what paces every
// operation. A new item is taken while the previous result still waits at the output.
module interval_set_merge_table_unit #(
	parameter int MAX_INTERVALS = ismt_pkg::MAX_INTERVALS_DEF,
	parameter int VALUE_BITS    = ismt_pkg::VALUE_BITS_DEF,
	localparam int CB           = $clog2(MAX_INTERVALS + 1),
	localparam int IN_W         = ((2 * VALUE_BITS + 7) / 8) * 8,
	localparam int OUT_W        = ((2 * VALUE_BITS + CB + 7) / 8) * 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [IN_W-1:0]  s_tdata,  // range_start, range_end
	input  logic             s_tuser,  // cmd
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [OUT_W-1:0] m_tdata,  // interval_low, interval_high, interval_count
	output logic [1:0]       m_tuser,  // status
	output logic             m_tlast   // last
);
	import ismt_pkg::*;

	dp_cmd_t                      cmd;
	dp_stat_t                     stat;
	logic signed [VALUE_BITS-1:0] interval_low, interval_high;
	logic [CB-1:0]                interval_count;

	ismt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	ismt_datapath #(
		.MAX_INTERVALS (MAX_INTERVALS),
		.VALUE_BITS    (VALUE_BITS)
	) u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.stat           (stat),
		.list_req       (s_tuser),
		.range_start    ($signed(s_tdata[VALUE_BITS-1:0])),
		.range_end      ($signed(s_tdata[2*VALUE_BITS-1:VALUE_BITS])),
		.out_valid      (m_tvalid),
		.out_ready      (m_tready),
		.status         (m_tuser),
		.interval_low   (interval_low),
		.interval_high  (interval_high),
		.interval_count (interval_count),
		.last           (m_tlast)
	);

	assign m_tdata = OUT_W'({interval_count, interval_high, interval_low});

endmodule
